### design/pvse_pkg.sv
// ----------------------------------------------------------------------------
// pvse_pkg: shared definitions for the partitioned vertex set engine
// Action codes, undo stack geometry and parameter defaults.
// ----------------------------------------------------------------------------
package pvse_pkg;

    // Default number of vertices held in the permutation tables.
    localparam int VERTEX_COUNT_DEF = 1024;

    // Undo stack geometry.
    localparam int UNDO_SLOTS = 1024;
    localparam int UNDO_AW    = 10;

    // Action codes carried on the input kind field.
    typedef enum logic [2:0] {
        ACT_INTERSECT = 3'd0,
        ACT_EXCLUDE   = 3'd1,
        ACT_COUNT     = 3'd2,
        ACT_MOVE_X    = 3'd3,
        ACT_RESTORE   = 3'd4,
        ACT_READ_P    = 3'd5,
        ACT_READ_X    = 3'd6,
        ACT_NONE      = 3'd7
    } t_action;

endpackage

### design/partitioned_vertex_set_engine_unit.sv
// ----------------------------------------------------------------------------
// partitioned_vertex_set_engine_unit
// One item is in work at a time. Stream element: S_RDA, S_LOOK, S_SWR and
// S_SWW on a swap, S_FIN, and S_EMIT on the last; move: S_RDA, S_LOOK, the
// swap if accepted, S_EMIT; reads: S_RDA, S_LOOK, S_EMIT; unused code: S_EMIT;
// restore: S_POP, S_POPD and a swap per popped entry, S_EMIT. A stalled output
// holds the next transfer. Reset: synchronous, active low, then identity fill.
// ----------------------------------------------------------------------------
module partitioned_vertex_set_engine_unit
    import pvse_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // vertex[9:0], position_index[20:10], restore_p_start[31:21],
    // restore_x_size[42:32], restore_p_size[53:43], restore_mark[64:54]
    input  logic [71:0] i_s_axis_tdata,
    // action[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // found_vertex[9:0], view_p_start[20:10], view_x_size[31:21],
    // view_p_size[42:32], undo_mark[53:43], member_count[64:54]
    output logic [71:0] o_m_axis_tdata,
    // found[0]
    output logic        o_m_axis_tuser
);

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int CW = ((AW > 11) ? AW : 11) + 2;
    localparam logic [CW-1:0] VC_W  = CW'(VERTEX_COUNT);
    localparam logic [CW-1:0] SAT_W = CW'(2047);
    localparam logic [AW-1:0] CLR_LAST = AW'(VERTEX_COUNT - 1);

    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_RDA  = 10'b0000000100,
        S_LOOK = 10'b0000001000,
        S_SWR  = 10'b0000010000,
        S_SWW  = 10'b0000100000,
        S_POP  = 10'b0001000000,
        S_POPD = 10'b0010000000,
        S_FIN  = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } t_state;

    t_state r_state;

    // Permutation tables and undo stack.
    logic [AW-1:0] vap_mem [VERTEX_COUNT];
    logic [AW-1:0] pov_mem [VERTEX_COUNT];
    logic [UNDO_AW-1:0] undo_mem [UNDO_SLOTS];
    logic [AW-1:0] r_vap_q;
    logic [AW-1:0] r_pov_q;
    logic [UNDO_AW-1:0] r_undo_q;

    // View and run state.
    logic [CW-1:0] r_ps, r_psz, r_xs, r_rp, r_rx;
    logic [10:0]   r_depth, r_run_mark;
    logic          r_run_active;
    logic [AW-1:0] r_clr;

    // Current item.
    t_action       r_act;
    logic [CW-1:0] r_cur, r_t, r_loc, r_idx;
    logic [AW-1:0] r_va;
    logic          r_last;
    logic [10:0]   r_rps, r_rxs, r_rpsz, r_rmark;

    // Pending result and output register.
    logic [10:0]   r_res_mark, r_res_cnt;
    logic [9:0]    r_res_fv;
    logic          r_res_found;
    logic          r_ov;
    logic [71:0]   r_odata;
    logic          r_ouser;

    // Input field slices.
    logic [9:0]    w_in_v;
    logic [10:0]   w_in_idx, w_in_rps, w_in_rxs, w_in_rpsz, w_in_rmark;
    t_action       w_in_act;
    logic          w_accept;

    assign w_in_v     = i_s_axis_tdata[9:0];
    assign w_in_idx   = i_s_axis_tdata[20:10];
    assign w_in_rps   = i_s_axis_tdata[31:21];
    assign w_in_rxs   = i_s_axis_tdata[42:32];
    assign w_in_rpsz  = i_s_axis_tdata[53:43];
    assign w_in_rmark = i_s_axis_tdata[64:54];
    assign w_in_act   = t_action'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    // Membership tests and swap target for the element under lookup.
    logic [CW-1:0] w_loc, w_t, w_rd_t, w_e;
    logic          w_vok, w_in_p, w_in_x, w_swap, w_rd_ok;

    assign w_loc = CW'(r_pov_q);
    assign w_e   = CW'(r_undo_q);
    assign w_vok = (r_cur < VC_W);
    assign w_in_p = w_vok && (w_loc >= r_ps) && (w_loc < r_ps + r_psz);
    assign w_in_x = w_vok && (w_loc < r_ps) && (w_loc + r_xs >= r_ps);

    always_comb begin
        w_t    = r_ps;
        w_swap = 1'b0;
        case (r_act)
            ACT_INTERSECT: begin
                if (w_in_p) begin
                    w_t    = r_ps + r_rp;
                    w_swap = (r_rp < r_psz) && (w_t < VC_W);
                end else if (w_in_x) begin
                    w_t    = r_ps - r_rx - CW'(1);
                    w_swap = (r_rx < r_xs) && (r_ps > r_rx) && (w_t < VC_W);
                end
            end
            ACT_EXCLUDE: begin
                w_t    = r_ps + r_psz - r_rp - CW'(1);
                w_swap = w_in_p && (r_rp < r_psz) && (w_t < VC_W);
            end
            ACT_MOVE_X: begin
                w_t    = r_ps;
                w_swap = w_in_p && (r_depth < 11'(UNDO_SLOTS));
            end
            ACT_RESTORE: begin
                w_t    = r_ps - CW'(1);
                w_swap = 1'b1;
            end
            default: begin
                w_t    = r_ps;
                w_swap = 1'b0;
            end
        endcase
    end

    // Read target for the element reads, and its range check.
    always_comb begin
        if (r_act == ACT_READ_P) begin
            w_rd_t = r_ps + r_idx;
        end else begin
            w_rd_t = r_ps - r_idx - CW'(1);
        end
        if (r_act == ACT_READ_P) begin
            w_rd_ok = (r_idx < r_psz) && (r_t < VC_W);
        end else begin
            w_rd_ok = (r_idx < r_xs) && (r_ps > r_idx) && (r_t < VC_W);
        end
    end

    // Read address selection.
    logic [AW-1:0] w_pov_ra, w_vap_ra;
    always_comb begin
        w_pov_ra = r_cur[AW-1:0];
        if (r_state == S_POPD) begin
            w_pov_ra = w_e[AW-1:0];
        end
        w_vap_ra = w_t[AW-1:0];
        if (r_state == S_RDA) begin
            w_vap_ra = w_rd_t[AW-1:0];
        end
    end

    // Memory ports: one write and one registered read per table.
    always_ff @(posedge i_clk) begin
        r_vap_q  <= vap_mem[w_vap_ra];
        r_pov_q  <= pov_mem[w_pov_ra];
        r_undo_q <= undo_mem[UNDO_AW'(r_depth - 11'd1)];
        if (r_state == S_CLR) begin
            vap_mem[r_clr] <= r_clr;
            pov_mem[r_clr] <= r_clr;
        end else if (r_state == S_SWR) begin
            vap_mem[r_t[AW-1:0]]   <= r_cur[AW-1:0];
            pov_mem[r_cur[AW-1:0]] <= r_t[AW-1:0];
        end else if (r_state == S_SWW) begin
            vap_mem[r_loc[AW-1:0]] <= r_va;
            pov_mem[r_va]          <= r_loc[AW-1:0];
        end
        if (r_state == S_LOOK && r_act == ACT_MOVE_X && w_swap) begin
            undo_mem[r_depth[UNDO_AW-1:0]] <= r_cur[UNDO_AW-1:0];
        end
    end

    // Sequencer and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_ov         <= 1'b0;
            r_depth      <= '0;
            r_ps         <= '0;
            r_psz        <= VC_W;
            r_xs         <= '0;
            r_rp         <= '0;
            r_rx         <= '0;
            r_run_mark   <= '0;
            r_run_active <= 1'b0;
        end else begin
            // The emit state reloads the output register itself.
            if (r_ov && i_m_axis_tready && r_state != S_EMIT) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_act       <= w_in_act;
                        r_cur       <= CW'(w_in_v);
                        r_last      <= i_s_axis_tlast;
                        r_idx       <= CW'(w_in_idx);
                        r_rps       <= w_in_rps;
                        r_rxs       <= w_in_rxs;
                        r_rpsz      <= w_in_rpsz;
                        r_rmark     <= w_in_rmark;
                        r_res_mark  <= r_depth;
                        r_res_found <= 1'b0;
                        r_res_fv    <= '0;
                        r_res_cnt   <= '0;
                        if (w_in_act == ACT_INTERSECT || w_in_act == ACT_EXCLUDE ||
                            w_in_act == ACT_COUNT) begin
                            if (!r_run_active) begin
                                r_run_active <= 1'b1;
                                r_run_mark   <= r_depth;
                                r_rp         <= '0;
                                r_rx         <= '0;
                            end
                        end
                        case (w_in_act)
                            ACT_RESTORE: r_state <= S_POP;
                            ACT_NONE:    r_state <= S_EMIT;
                            default:     r_state <= S_RDA;
                        endcase
                    end
                end
                S_RDA: begin
                    r_t     <= w_rd_t;
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_loc <= w_loc;
                    r_t   <= w_t;
                    case (r_act)
                        ACT_COUNT: begin
                            if (w_in_p && r_rp < SAT_W) begin
                                r_rp <= r_rp + CW'(1);
                            end
                            r_state <= S_FIN;
                        end
                        ACT_READ_P, ACT_READ_X: begin
                            r_res_found <= w_rd_ok;
                            r_res_fv    <= w_rd_ok ? 10'(CW'(r_vap_q)) : 10'd0;
                            r_state     <= S_EMIT;
                        end
                        ACT_MOVE_X: begin
                            if (w_swap) begin
                                r_depth     <= r_depth + 11'd1;
                                r_ps        <= r_ps + CW'(1);
                                r_xs        <= r_xs + CW'(1);
                                r_psz       <= r_psz - CW'(1);
                                r_res_found <= 1'b1;
                                r_state     <= S_SWR;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                        ACT_RESTORE: begin
                            r_ps    <= r_ps - CW'(1);
                            r_state <= S_SWR;
                        end
                        default: begin
                            if (w_swap) begin
                                if (r_act == ACT_INTERSECT && !w_in_p) begin
                                    r_rx <= r_rx + CW'(1);
                                end else begin
                                    r_rp <= r_rp + CW'(1);
                                end
                                r_state <= S_SWR;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    endcase
                end
                S_SWR: begin
                    r_va    <= r_vap_q;
                    r_state <= S_SWW;
                end
                S_SWW: begin
                    case (r_act)
                        ACT_RESTORE: r_state <= S_POP;
                        ACT_MOVE_X:  r_state <= S_EMIT;
                        default:     r_state <= S_FIN;
                    endcase
                end
                S_POP: begin
                    if (r_depth > r_rmark) begin
                        r_depth <= r_depth - 11'd1;
                        r_state <= S_POPD;
                    end else begin
                        r_ps         <= CW'(r_rps);
                        r_xs         <= CW'(r_rxs);
                        r_psz        <= CW'(r_rpsz);
                        r_run_active <= 1'b0;
                        r_rp         <= '0;
                        r_rx         <= '0;
                        r_state      <= S_EMIT;
                    end
                end
                S_POPD: begin
                    // The popped vertex returns to the slot just below P.
                    if (r_ps != '0) begin
                        if (w_e < VC_W && (r_ps - CW'(1)) < VC_W) begin
                            r_cur   <= w_e;
                            r_state <= S_LOOK;
                        end else begin
                            r_ps    <= r_ps - CW'(1);
                            r_state <= S_POP;
                        end
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_FIN: begin
                    if (r_last) begin
                        case (r_act)
                            ACT_INTERSECT: begin
                                r_psz <= r_rp;
                                r_xs  <= r_rx;
                            end
                            ACT_EXCLUDE: r_psz <= r_psz - r_rp;
                            default:     r_res_cnt <= 11'(r_rp);
                        endcase
                        r_res_mark   <= r_run_mark;
                        r_run_active <= 1'b0;
                        r_rp         <= '0;
                        r_rx         <= '0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!r_ov || i_m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_odata <= {7'd0, r_res_cnt, r_res_mark, 11'(r_psz),
                                    11'(r_xs), 11'(r_ps), r_res_fv};
                        r_ouser <= r_res_found;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
